FILE: rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on clk and quiet while rst_n is low.
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked on clk and quiet while rst_n is low.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/core/mcr_pkg.sv
`timescale 1ns / 1ps

package mcr_pkg;

  localparam int unsigned CoordW  = 10;  // center and radius registers
  localparam int unsigned OffsetW = 11;  // x / y offsets from the center
  localparam int unsigned DecW    = 14;  // midpoint decision value
  localparam int unsigned PointW  = 12;  // emitted coordinates, two's complement
  localparam int unsigned IdxW    = 3;   // point index within a group
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 2 * PointW;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_CENTER_X = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_CENTER_Y = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_RADIUS   = 2'd2;

  typedef struct packed {
    logic signed [PointW-1:0] point_y;
    logic signed [PointW-1:0] point_x;
    logic                     last;
  } mcr_point_t;

endpackage

FILE: rtl/core/midpoint_circle_rasterizer_unit.sv
`timescale 1ns / 1ps

// Midpoint circle rasterizer.
// Write center_x (index 0), center_y (index 1) and radius (index 2) on the
// cfg_ port while idle, then send one tick word per point on in_. A tick with
// in_tdata[0] set starts a new circle; each tick yields one point word on
// out_, in order: four cardinal points, then groups of eight reflected points
// after each midpoint step. The final point carries out_tlast. Ticks while no
// circle is active are taken and produce nothing.
// Each point word is registered in the point register, or in the skid
// register while out_ stalls. Throughput: one tick and one point per cycle
// while in_tready is high; all work for a tick is a few narrow adds and a
// mux between the walk state registers and the point register.
// Stall: a two-word output buffer (point register plus skid register) keeps
// in_tready high while one finished point waits; in_tready drops only when
// both are full, and no word is lost or repeated.
// Reset (rst_n low, synchronous): configuration and walk registers clear to
// zero, no circle active, output buffer empty; point data is not reset.

module midpoint_circle_rasterizer_unit
  import mcr_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // configuration write port
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CoordW-1:0]   cfg_data,
  // tick words
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,   // [0] start_req, [7:1] zero
  // point words
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata,  // [11:0] point_x, [23:12] point_y
  output logic                out_tlast   // last
);

  typedef enum logic [1:0] {PH_IDLE, PH_CARD, PH_OCT} phase_t;

  // configuration
  logic [CoordW-1:0] center_x_r, center_y_r, radius_r;

  // walk state
  phase_t                  phase_r, phase_nxt;
  logic [OffsetW-1:0]      offset_major_r, offset_major_nxt;
  logic [OffsetW-1:0]      offset_minor_r, offset_minor_nxt;
  logic signed [DecW-1:0]  decision_r, decision_nxt;
  logic [IdxW-1:0]         emit_index_r, emit_index_nxt;

  // output buffer
  mcr_point_t out_r, skid_r;
  logic       out_valid_r, skid_valid_r;

  // tick-time view of the state (start overrides the stored walk)
  logic                   acc, start;
  phase_t                 eff_phase;
  logic [OffsetW-1:0]     eff_major, eff_minor;
  logic signed [DecW-1:0] eff_dec;
  logic [IdxW-1:0]        eff_idx;

  // midpoint step
  logic [OffsetW-1:0]     step_minor, step_major;
  logic signed [DecW-1:0] step_dec;
  logic                   dec_pos, more;

  // point arithmetic
  logic signed [PointW-1:0] cx, cy, a, b;
  mcr_point_t res;
  logic       has_res;

  assign acc   = in_tvalid && in_tready;
  assign start = in_tdata[0];
  assign in_tready = !skid_valid_r;

  always_comb begin
    if (start) begin
      eff_phase = PH_CARD;
      eff_major = {1'b0, radius_r};
      eff_minor = '0;
      eff_dec   = 14'sd1 - $signed({{(DecW-CoordW){1'b0}}, radius_r});
      eff_idx   = '0;
    end else begin
      eff_phase = phase_r;
      eff_major = offset_major_r;
      eff_minor = offset_minor_r;
      eff_dec   = decision_r;
      eff_idx   = emit_index_r;
    end
  end

  // one midpoint step: y += 1; x -= 1 when the decision value is positive
  always_comb begin
    dec_pos    = (eff_dec > 14'sd0);
    step_minor = eff_minor + 11'd1;
    step_major = dec_pos ? (eff_major - 11'd1) : eff_major;
    step_dec   = eff_dec + $signed({2'b00, step_minor, 1'b0}) + 14'sd1
               - (dec_pos ? $signed({2'b00, step_major, 1'b0}) : 14'sd0);
    more       = (eff_major > eff_minor);
  end

  assign cx = $signed({2'b00, center_x_r});
  assign cy = $signed({2'b00, center_y_r});
  assign a  = $signed({1'b0, eff_major});
  assign b  = $signed({1'b0, eff_minor});

  always_comb begin
    res              = '0;
    has_res          = 1'b0;
    phase_nxt        = eff_phase;
    offset_major_nxt = eff_major;
    offset_minor_nxt = eff_minor;
    decision_nxt     = eff_dec;
    emit_index_nxt   = eff_idx + 3'd1;
    unique case (eff_phase)
      PH_IDLE: begin
        emit_index_nxt = eff_idx;
      end
      PH_CARD: begin
        has_res = 1'b1;
        case (eff_idx[1:0])
          2'd0:    begin res.point_x = cx + a; res.point_y = cy;     end
          2'd1:    begin res.point_x = cx - a; res.point_y = cy;     end
          2'd2:    begin res.point_x = cx;     res.point_y = cy + a; end
          default: begin res.point_x = cx;     res.point_y = cy - a; end
        endcase
        if (eff_idx[1:0] == 2'd3) begin
          emit_index_nxt = '0;
          if (more) begin
            phase_nxt        = PH_OCT;
            offset_major_nxt = step_major;
            offset_minor_nxt = step_minor;
            decision_nxt     = step_dec;
          end else begin
            res.last  = 1'b1;
            phase_nxt = PH_IDLE;
          end
        end
      end
      PH_OCT: begin
        has_res = 1'b1;
        case (eff_idx)
          3'd0:    begin res.point_x = cx + a; res.point_y = cy + b; end
          3'd1:    begin res.point_x = cx - a; res.point_y = cy + b; end
          3'd2:    begin res.point_x = cx + a; res.point_y = cy - b; end
          3'd3:    begin res.point_x = cx - a; res.point_y = cy - b; end
          3'd4:    begin res.point_x = cx + b; res.point_y = cy + a; end
          3'd5:    begin res.point_x = cx - b; res.point_y = cy + a; end
          3'd6:    begin res.point_x = cx + b; res.point_y = cy - a; end
          default: begin res.point_x = cx - b; res.point_y = cy - a; end
        endcase
        if (eff_idx == 3'd7) begin
          emit_index_nxt = '0;
          if (more) begin
            offset_major_nxt = step_major;
            offset_minor_nxt = step_minor;
            decision_nxt     = step_dec;
          end else begin
            res.last  = 1'b1;
            phase_nxt = PH_IDLE;
          end
        end
      end
      default: begin
        phase_nxt      = PH_IDLE;
        emit_index_nxt = '0;
      end
    endcase
  end

  // configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
      radius_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CENTER_X: center_x_r <= cfg_data;
        CFG_CENTER_Y: center_y_r <= cfg_data;
        CFG_RADIUS:   radius_r   <= cfg_data;
        default:      ;
      endcase
    end
  end

  // walk state advances once per accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      offset_major_r <= '0;
      offset_minor_r <= '0;
      decision_r     <= '0;
      emit_index_r   <= '0;
    end else if (acc) begin
      phase_r        <= phase_nxt;
      offset_major_r <= offset_major_nxt;
      offset_minor_r <= offset_minor_nxt;
      decision_r     <= decision_nxt;
      emit_index_r   <= emit_index_nxt;
    end
  end

  // output register with skid: the skid fills only when the output stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_tready || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= acc && has_res;
      end
    end else if (acc && has_res) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_tready || !out_valid_r) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (acc && has_res) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r.point_y, out_r.point_x};
  assign out_tlast  = out_r.last;

`include "assert_macros.svh"

  `ASSERT_IMPLIES(a_skid_behind_out, skid_valid_r, out_valid_r)
  `ASSERT_NEXT(a_last_ends_walk, acc && has_res && res.last, phase_r == PH_IDLE)
  `ASSERT_IMPLIES(a_card_index_range, phase_r == PH_CARD, emit_index_r[2] == 1'b0)

endmodule
